### design/ddd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddd_pkg: shared types and constants for the date difference block
// Stage enables, reciprocal constants for the decimal split and the
// cumulative month table.
// ----------------------------------------------------------------------------
package ddd_pkg;

  // Field widths
  localparam int DATE_W  = 27;
  localparam int COUNT_W = 22;
  localparam int DAYN_W  = 23;   // serial day number, max year 13421
  localparam int YEAR_W  = 14;

  // Pipeline depth: four lane stages plus the output register
  localparam int NUM_STAGES = 5;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // v / 10000 = (v * DIV10K_MUL) >> DIV10K_SHIFT, exact for v < 2**27
  localparam logic [26:0] DIV10K_MUL   = 27'd109951163;
  localparam int          DIV10K_SHIFT = 40;
  localparam logic [13:0] TEN_K        = 14'd10000;

  // x / 100 = (x * DIV100_MUL) >> DIV100_SHIFT, exact for x < 43690
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic [COUNT_W-1:0] DAY_COUNT_MAX = 22'd4194303;

  // Days in the whole months before month index m (0 = January)
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

endpackage

### design/ddd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddd_lane: packed YYYYMMDD date to serial day number
// Four registered stages: divide by 10000, split year terms, split month and
// day, sum the day number.
// ----------------------------------------------------------------------------
module ddd_lane (
  input  logic                       clk,
  input  ddd_pkg::stage_en_t         en,
  input  logic [ddd_pkg::DATE_W-1:0] date,
  output logic [ddd_pkg::DAYN_W-1:0] day_num
);
  import ddd_pkg::*;

  // x / 100 by reciprocal multiply, x below 43690
  function automatic logic [9:0] div100(input logic [15:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'(DIV100_MUL);
    return p[28:DIV100_SHIFT];
  endfunction

  // Stage 1: reciprocal product for the year
  logic [53:0]       p1;
  logic [DATE_W-1:0] v1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1 <= 54'(date) * 54'(DIV10K_MUL);
      v1 <= date;
    end
  end

  // Stage 2: year, MMDD remainder and the century terms
  logic [YEAR_W-1:0] y1;
  logic [27:0]       y_x10k;
  logic [14:0]       y_p99;
  logic [14:0]       y_p399;
  logic [YEAR_W-1:0] y2;
  logic [13:0]       r2;
  logic [9:0]        q100_2;
  logic [9:0]        c100_2;
  logic [9:0]        c400_2;

  always_comb begin
    y1     = p1[53:DIV10K_SHIFT];
    y_x10k = 28'(y1) * 28'(TEN_K);
    y_p99  = 15'(y1) + 15'd99;
    y_p399 = 15'(y1) + 15'd399;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      y2     <= y1;
      r2     <= 14'(v1 - y_x10k[DATE_W-1:0]);
      q100_2 <= div100(16'(y1));
      c100_2 <= div100(16'(y_p99));
      c400_2 <= div100(16'(y_p399 >> 2));
    end
  end

  // Stage 3: month index, day, leap flag and days of the whole years
  logic [9:0]        m_raw;
  logic [6:0]        d_raw;
  logic [3:0]        m_idx;
  logic              cent;
  logic              leap;
  logic [14:0]       y_p3;
  logic [DAYN_W-1:0] n_years;
  logic [3:0]        m3;
  logic [6:0]        d3;
  logic              leap3;
  logic [DAYN_W-1:0] ny3;

  always_comb begin
    m_raw = div100(16'(r2));
    d_raw = 7'(r2 - 14'(m_raw) * 14'd100);
    // month zero counts as January, past twelve as December
    if (m_raw == 10'd0)       m_idx = 4'd0;
    else if (m_raw > 10'd12)  m_idx = 4'd11;
    else                      m_idx = 4'(m_raw - 10'd1);
    cent    = (y2 == 14'(q100_2) * 14'd100);
    leap    = ((y2[1:0] == 2'd0) && !cent) || (cent && (q100_2[1:0] == 2'd0));
    y_p3    = 15'(y2) + 15'd3;
    n_years = 23'(y2) * 23'd365 + 23'(y_p3 >> 2) - 23'(c100_2) + 23'(c400_2);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m3    <= m_idx;
      d3    <= d_raw;
      leap3 <= leap;
      ny3   <= n_years;
    end
  end

  // Stage 4: day number
  always_ff @(posedge clk) begin
    if (en[3]) begin
      day_num <= ny3 + 23'(days_before_month(m3))
               + 23'(leap3 && (m3 >= 4'd2)) + 23'(d3);
    end
  end

endmodule

### design/ddd_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddd_merge: combines the two lane day numbers
// Absolute difference plus one, saturated to the count width, held in the
// output register.
// ----------------------------------------------------------------------------
module ddd_merge (
  input  logic                        clk,
  input  ddd_pkg::stage_en_t          en,
  input  logic [ddd_pkg::DAYN_W-1:0]  day_a,
  input  logic [ddd_pkg::DAYN_W-1:0]  day_b,
  output logic [ddd_pkg::COUNT_W-1:0] day_count
);
  import ddd_pkg::*;

  logic [DAYN_W-1:0] diff;
  logic [DAYN_W:0]   cnt;

  // inclusive distance between the two day numbers
  always_comb begin
    diff = (day_a >= day_b) ? (day_a - day_b) : (day_b - day_a);
    cnt  = (DAYN_W+1)'(diff) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      day_count <= (cnt > (DAYN_W+1)'(DAY_COUNT_MAX)) ? DAY_COUNT_MAX
                                                      : cnt[COUNT_W-1:0];
    end
  end

endmodule

### design/date_difference_days_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_difference_days_core: inclusive day count between two dates
// Two lanes turn the dates into day numbers side by side; a merge stage
// takes the inclusive distance.
// ----------------------------------------------------------------------------
//  channel | dir | word                              | tuser / tlast
//  s_axis  | in  | [26:0] first_date, [53:27] second | none
//  m_axis  | out | [21:0] day_count                  | none
//
//  One date pair per cycle sustained while m_tready is high.
//  Latency is set by the reciprocal multiplies for the decimal split.
//  Each stage has its own valid bit and advances when the next one is free,
//  so bubbles close up while the output word waits.
//  Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module date_difference_days_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [26:0] first_date, [53:27] second_date, pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [21:0] day_count, pad
);
  import ddd_pkg::*;

  stage_en_t                en;
  logic [NUM_STAGES-1:0]    vld;
  logic [DAYN_W-1:0]        day_a;
  logic [DAYN_W-1:0]        day_b;
  logic [COUNT_W-1:0]       day_count;

  // Stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int i = NUM_STAGES-2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Lanes
  ddd_lane u_lane_a (
    .clk     (clk),
    .en      (en),
    .date    (s_tdata[26:0]),
    .day_num (day_a)
  );

  ddd_lane u_lane_b (
    .clk     (clk),
    .en      (en),
    .date    (s_tdata[53:27]),
    .day_num (day_b)
  );

  ddd_merge u_merge (
    .clk       (clk),
    .en        (en),
    .day_a     (day_a),
    .day_b     (day_b),
    .day_count (day_count)
  );

  assign s_tready = en[0];
  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tdata  = {2'b00, day_count};

  // Assertions
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted word did not enter the first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !m_tready |-> !s_tready)
    else $error("ready high with a full stalled pipeline");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:0] != 22'd0))
    else $error("day count of zero delivered");

  a_drain_bubble: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !vld[NUM_STAGES-2] |=> !m_tvalid)
    else $error("output valid without a word behind it");

endmodule
